/* src/xtea_block_encrypt_macros.svh */
// ============================================================================
// XTEA block encrypt assertion macros
// Concurrent assertion wrappers that check in simulation and drop out in
// synthesis. They expect i_clk and i_rst_n in the calling module.
// ============================================================================
`ifndef XTEA_BLOCK_ENCRYPT_MACROS_SVH
`define XTEA_BLOCK_ENCRYPT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every clock edge outside reset.
`define XTEA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XTEA_ASSERT_IMPL(lbl, ante, cons, msg)
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/xtea_pkg.sv */
// ============================================================================
// XTEA package
// Types, constants and helper functions shared by the XTEA encrypt pipeline.
// ============================================================================
package xtea_pkg;

    localparam int          XTEA_ROUND_COUNT = 32;
    localparam int          WORD_W           = 32;
    localparam int          KEY_WORDS        = 4;
    localparam int          KEY_SEL_SHIFT    = 11;
    localparam int          CFG_INDEX_W      = 4;
    localparam logic [31:0] XTEA_DELTA       = 32'h9e37_79b9;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_0 = 4'd0,
        CFG_KEY_1 = 4'd1,
        CFG_KEY_2 = 4'd2,
        CFG_KEY_3 = 4'd3
    } t_cfg_reg;

    // One block in flight between pipeline stages.
    typedef struct packed {
        logic  valid;
        t_word v0;
        t_word v1;
    } t_pipe;

    function automatic t_word f_mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Running sum after a number of delta additions; only used on constants.
    function automatic t_word f_round_sum(input int unsigned steps);
        logic [63:0] prod;
        prod = 64'(steps) * 64'(XTEA_DELTA);
        return prod[WORD_W-1:0];
    endfunction

endpackage

/* src/xtea_round.sv */
// ============================================================================
// XTEA round
// One cipher round as two register stages, one per Feistel half-step. The
// running sum is fixed per round, so the key word choice is wired at build.
// ============================================================================
module xtea_round #(
    parameter int ROUND_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  xtea_pkg::t_key i_key,
    input  xtea_pkg::t_pipe i_stage,
    output xtea_pkg::t_pipe o_stage
);
    import xtea_pkg::*;

    localparam t_word      SUM_A     = f_round_sum(ROUND_IDX);
    localparam t_word      SUM_B     = f_round_sum(ROUND_IDX + 1);
    localparam logic [1:0] KEY_SEL_A = SUM_A[1:0];
    localparam logic [1:0] KEY_SEL_B = SUM_B[KEY_SEL_SHIFT +: 2];

    t_pipe r_half;
    t_pipe r_full;
    t_pipe n_half;
    t_pipe n_full;

    always_comb begin
        n_half.valid = i_stage.valid;
        n_half.v0    = i_stage.v0 + (f_mix(i_stage.v1) ^ (SUM_A + i_key[KEY_SEL_A]));
        n_half.v1    = i_stage.v1;

        n_full.valid = r_half.valid;
        n_full.v0    = r_half.v0;
        n_full.v1    = r_half.v1 + (f_mix(r_half.v0) ^ (SUM_B + i_key[KEY_SEL_B]));
    end

    // Only the valid bits are reset; the data words follow the enable alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half.valid <= 1'b0;
            r_full.valid <= 1'b0;
        end else if (i_en) begin
            r_half.valid <= n_half.valid;
            r_full.valid <= n_full.valid;
        end
        if (i_en) begin
            r_half.v0 <= n_half.v0;
            r_half.v1 <= n_half.v1;
            r_full.v0 <= n_full.v0;
            r_full.v1 <= n_full.v1;
        end
    end

    assign o_stage = r_full;

endmodule

/* src/xtea_out_skid.sv */
// ============================================================================
// XTEA output buffer
// Output register plus one skid entry. The pipeline advances while the skid
// entry is empty; it takes one result behind a stalled output, then the pipeline holds.
// ============================================================================
`include "xtea_block_encrypt_macros.svh"

module xtea_out_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xtea_pkg::t_pipe i_stage,
    output logic            o_en,
    input  logic            i_ready,
    output xtea_pkg::t_pipe o_stage
);
    import xtea_pkg::*;

    t_pipe r_out;
    t_pipe r_skid;
    logic  n_out_valid;
    logic  n_skid_valid;
    logic  w_load_out;
    logic  w_load_skid;
    logic  w_skid_to_out;

    always_comb begin
        w_skid_to_out = r_skid.valid && i_ready;
        w_load_out    = !r_skid.valid && (!r_out.valid || i_ready);
        w_load_skid   = !r_skid.valid && r_out.valid && !i_ready && i_stage.valid;

        n_out_valid  = r_out.valid;
        n_skid_valid = r_skid.valid;
        if (w_skid_to_out) begin
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end else if (w_load_out) begin
            n_out_valid = i_stage.valid;
        end else if (w_load_skid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out.valid  <= n_out_valid;
            r_skid.valid <= n_skid_valid;
        end
        if (w_skid_to_out) begin
            r_out.v0 <= r_skid.v0;
            r_out.v1 <= r_skid.v1;
        end else if (w_load_out) begin
            r_out.v0 <= i_stage.v0;
            r_out.v1 <= i_stage.v1;
        end
        if (w_load_skid) begin
            r_skid.v0 <= i_stage.v0;
            r_skid.v1 <= i_stage.v1;
        end
    end

    assign o_en    = !r_skid.valid;
    assign o_stage = r_out;

    `XTEA_ASSERT_IMPL(a_skid_behind_out, r_skid.valid, r_out.valid, "skid full with output empty")
    `XTEA_ASSERT_IMPL(a_skid_fill_on_stall, $rose(r_skid.valid), $past(r_out.valid && !i_ready), "skid filled without a stalled output")
    `XTEA_ASSERT_NEXT(a_skid_drains, r_skid.valid && i_ready, r_out.valid && !r_skid.valid, "skid entry lost on drain")

endmodule

/* src/xtea_block_encrypt.sv */
// ============================================================================
// XTEA block encrypt
// Fully unrolled XTEA encryption pipeline with a stream interface.
// ============================================================================
// Each request carries one 64-bit plaintext block and yields one ciphertext
// block. Every round is unrolled into two register stages, one per half-step,
// so the block takes a new request every cycle while its skid entry is empty;
// a result passes through all round stages and then the output register.
// When the output is stalled, one skid entry absorbs the result in flight
// and the whole pipeline then holds. The key is loaded through the
// configuration channel, one 32-bit word per request, and must only change
// while no block is in flight.
module xtea_block_encrypt #(
    parameter int ROUND_COUNT = xtea_pkg::XTEA_ROUND_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]      i_cfg_data,
    // Plaintext stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [2*xtea_pkg::WORD_W-1:0]    s_axis_tdata,   // {plain_second, plain_first}
    // Ciphertext stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [2*xtea_pkg::WORD_W-1:0]    m_axis_tdata    // {cipher_second, cipher_first}
);
    import xtea_pkg::*;

    t_key  r_key;
    t_pipe w_stage [ROUND_COUNT+1];
    t_pipe w_out;
    logic  w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_KEY_0: r_key[0] <= i_cfg_data;
                CFG_KEY_1: r_key[1] <= i_cfg_data;
                CFG_KEY_2: r_key[2] <= i_cfg_data;
                CFG_KEY_3: r_key[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Packed as {valid, v0, v1}.
    assign w_stage[0] = {s_axis_tvalid, s_axis_tdata[WORD_W-1:0],
                         s_axis_tdata[2*WORD_W-1:WORD_W]};

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        xtea_round #(
            .ROUND_IDX (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    xtea_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage[ROUND_COUNT]),
        .o_en    (w_en),
        .i_ready (m_axis_tready),
        .o_stage (w_out)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = w_out.valid;
    assign m_axis_tdata  = {w_out.v1, w_out.v0};

endmodule

/* tb/tb_xtea_block_encrypt.sv */
`timescale 1ns / 100ps
// ============================================================================
// XTEA block encrypt testbench
// Streams plaintext blocks through the encrypt pipeline under a series of
// keys. Each ciphertext is compared with a behavioral XTEA model kept in the
// testbench. The run uses random idling on both streams, a calm stretch, and
// one long output hold-off that backs the pipeline up to its input.
// ============================================================================
module tb_xtea_block_encrypt;
    import xtea_pkg::*;

    localparam int ROUNDS       = XTEA_ROUND_COUNT;
    localparam int PHASE_BLOCKS = 300;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        t_word plain_first;
        t_word plain_second;
    } t_plain_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [WORD_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [2*WORD_W-1:0]    s_axis_tdata  = '0;   // {plain_second, plain_first}
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*WORD_W-1:0]    m_axis_tdata;         // {cipher_second, cipher_first}

    logic [2*WORD_W-1:0] cipher_expected[$];
    t_key                key_now = '0;
    int                  blocks_sent = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;
    bit                  calm = 1'b0;

    // Corner plaintexts, walked once under the reset key and once under all ones.
    t_plain_row plain_corners [12] = '{
        '{32'h0000_0000, 32'h0000_0000},
        '{32'hffff_ffff, 32'hffff_ffff},
        '{32'h0000_0000, 32'hffff_ffff},
        '{32'hffff_ffff, 32'h0000_0000},
        '{32'h0000_0001, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0001},
        '{32'h8000_0000, 32'h8000_0000},
        '{32'h7fff_ffff, 32'h7fff_ffff},
        '{32'ha5a5_a5a5, 32'h5a5a_5a5a},
        '{32'h5a5a_5a5a, 32'ha5a5_a5a5},
        '{32'h4142_4344, 32'h4546_4748},
        '{32'h0123_4567, 32'h89ab_cdef}
    };

    xtea_block_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Ciphertext as {cipher_second, cipher_first}.
    function automatic logic [2*WORD_W-1:0] xtea_cipher(input t_word pf, input t_word ps,
                                                        input t_key k);
        t_word a;
        t_word b;
        t_word s;
        a = pf;
        b = ps;
        s = '0;
        for (int r = 0; r < ROUNDS; r++) begin
            a += (((b << 4) ^ (b >> 5)) + b) ^ (s + k[s[1:0]]);
            s += XTEA_DELTA;
            b += (((a << 4) ^ (a >> 5)) + a) ^ (s + k[s[KEY_SEL_SHIFT +: 2]]);
        end
        return {b, a};
    endfunction

    function automatic t_word random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_block(input t_word pf, input t_word ps);
        while (!calm && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ps, pf};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cipher_expected.push_back(xtea_cipher(pf, ps, key_now));
        blocks_sent++;
    endtask

    // Loads all four key words; a stray write to an unused index goes first
    // and must leave the key untouched.
    task automatic load_key(input t_key k);
        logic [CFG_INDEX_W-1:0] idx [KEY_WORDS+1];
        t_word                  val [KEY_WORDS+1];
        idx = '{CFG_INDEX_W'($urandom_range(KEY_WORDS, 2**CFG_INDEX_W - 1)),
                CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3};
        val = '{$urandom(), k[0], k[1], k[2], k[3]};
        for (int i = 0; i <= KEY_WORDS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (idx[i] < KEY_WORDS) key_now[idx[i][1:0]] = val[i];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cipher_expected.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_key next_key;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plain_corners[i])
            send_block(plain_corners[i].plain_first, plain_corners[i].plain_second);
        drain();
        load_key('1);
        foreach (plain_corners[i])
            send_block(plain_corners[i].plain_first, plain_corners[i].plain_second);

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                2:       next_key = '0;
                4:       next_key = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
                default: next_key = {$urandom(), $urandom(), $urandom(), $urandom()};
            endcase
            load_key(next_key);
            // One phase runs with no idling on either stream.
            calm = (p == 3);
            repeat (PHASE_BLOCKS) send_block(random_word(), random_word());
        end

        drain();
        repeat (2 * ROUNDS + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Output side: random stalls, plus one long hold-off that fills the pipeline.
    initial begin : cipher_sink
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && blocks_sent >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    always @(posedge i_clk) begin : cipher_check
        logic [2*WORD_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_expected.size() == 0) begin
                $display("%0t: ciphertext %h with no request pending", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = cipher_expected.pop_front();
                if (m_axis_tdata[WORD_W-1:0] !== want[WORD_W-1:0]) begin
                    $display("%0t: cipher_first expected %h actual %h", $time,
                             want[WORD_W-1:0], m_axis_tdata[WORD_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2*WORD_W-1:WORD_W] !== want[2*WORD_W-1:WORD_W]) begin
                    $display("%0t: cipher_second expected %h actual %h", $time,
                             want[2*WORD_W-1:WORD_W], m_axis_tdata[2*WORD_W-1:WORD_W]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

/* sim.f */
+incdir+src
src/xtea_pkg.sv
src/xtea_round.sv
src/xtea_out_skid.sv
src/xtea_block_encrypt.sv
tb/tb_xtea_block_encrypt.sv
